@@ src/evad_pkg.sv @@
package evad_pkg;

  localparam int HISTORY_DEPTH_DEF = 100;
  localparam int MAX_CHUNK_DEF = 4096;
  localparam int SAMPLE_W = 16;
  localparam int RMS_W = 16;
  localparam int RATIO_W = 8;
  localparam int COUNT_W = 7;
  localparam int CFG_IDX_W = 2;
  localparam int CFG_DATA_W = 8;
  localparam logic [RMS_W-1:0] FLOOR_RESET = 16'd33;
  localparam logic [RATIO_W-1:0] SPEECH_RATIO_RESET = 8'd40;
  localparam logic [RATIO_W-1:0] FLOOR_RATIO_RESET = 8'd24;
  localparam logic [COUNT_W-1:0] MIN_HISTORY_RESET = 7'd10;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_SPEECH_RATIO = 2'd0,
    REG_FLOOR_RATIO  = 2'd1,
    REG_MIN_HISTORY  = 2'd2
  } cfg_reg_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_DIV,
    ST_SQRT,
    ST_SCAN,
    ST_SCALE,
    ST_OUT
  } back_state_t;

endpackage

@@ src/energy_voice_activity_detector_unit.sv @@
// back end: a capture chunk result takes 45 divide steps (default MAX_CHUNK), 32 root steps
// and the hand-offs; a noise chunk also scans the history for its minimum and scales it
// into the floor, but skips both when the history count does not exceed min_history
// throughput: one sample per cycle within a chunk; the back end takes one chunk end at a
// time and a second chunk end waits in the front until the queued one is taken
// reset: synchronous active-high rst clears sums, counts, volume, floor to 33, config defaults
module energy_voice_activity_detector_unit #(
  parameter int HISTORY_DEPTH = evad_pkg::HISTORY_DEPTH_DEF,
  parameter int MAX_CHUNK = evad_pkg::MAX_CHUNK_DEF
) (
  input  logic                                 clk,
  input  logic                                 rst,
  input  logic                                 in_valid,
  output logic                                 in_ready,
  input  logic                                 opcode,
  input  logic signed [evad_pkg::SAMPLE_W-1:0] sample,
  input  logic                                 chunk_end,
  output logic                                 out_valid,
  input  logic                                 out_ready,
  output logic [evad_pkg::RMS_W-1:0]           volume,
  output logic [evad_pkg::RMS_W-1:0]           noise_floor,
  output logic                                 speech_detected,
  output logic [evad_pkg::COUNT_W-1:0]         history_count,
  input  logic                                 cfg_we,
  input  logic [evad_pkg::CFG_IDX_W-1:0]       cfg_index,
  input  logic [evad_pkg::CFG_DATA_W-1:0]      cfg_data
);

  localparam int LEN_W = $clog2(MAX_CHUNK + 1);
  localparam int SUM_W = 32 + LEN_W;

  logic [evad_pkg::RATIO_W-1:0] speech_ratio_q4;
  logic [evad_pkg::RATIO_W-1:0] floor_ratio_q4;
  logic [evad_pkg::COUNT_W-1:0] min_history;
  logic             q_valid, q_ready, q_op;
  logic [SUM_W-1:0] q_sum;
  logic [LEN_W-1:0] q_len;

  always_ff @(posedge clk) begin
    if (rst) begin
      speech_ratio_q4 <= evad_pkg::SPEECH_RATIO_RESET;
      floor_ratio_q4 <= evad_pkg::FLOOR_RATIO_RESET;
      min_history <= evad_pkg::MIN_HISTORY_RESET;
    end else if (cfg_we) begin
      case (evad_pkg::cfg_reg_t'(cfg_index))
        evad_pkg::REG_SPEECH_RATIO: speech_ratio_q4 <= cfg_data;
        evad_pkg::REG_FLOOR_RATIO:  floor_ratio_q4 <= cfg_data;
        evad_pkg::REG_MIN_HISTORY:  min_history <= cfg_data[evad_pkg::COUNT_W-1:0];
        default: ;
      endcase
    end
  end

  evad_front #(.MAX_CHUNK(MAX_CHUNK), .SUM_W(SUM_W), .LEN_W(LEN_W)) u_front (
    .clk, .rst, .in_valid, .in_ready, .opcode, .sample, .chunk_end,
    .q_valid, .q_ready, .q_sum, .q_len, .q_op
  );

  evad_back #(.HISTORY_DEPTH(HISTORY_DEPTH), .SUM_W(SUM_W), .LEN_W(LEN_W)) u_back (
    .clk, .rst, .q_valid, .q_ready, .q_sum, .q_len, .q_op,
    .speech_ratio_q4, .floor_ratio_q4, .min_history,
    .out_valid, .out_ready, .volume, .noise_floor, .speech_detected, .history_count
  );

endmodule

@@ src/evad_front.sv @@
module evad_front #(
  parameter int MAX_CHUNK = evad_pkg::MAX_CHUNK_DEF,
  parameter int SUM_W = 32 + $clog2(MAX_CHUNK + 1),
  parameter int LEN_W = $clog2(MAX_CHUNK + 1)
) (
  input  logic                           clk,
  input  logic                           rst,
  input  logic                           in_valid,
  output logic                           in_ready,
  input  logic                           opcode,
  input  logic signed [evad_pkg::SAMPLE_W-1:0] sample,
  input  logic                           chunk_end,
  output logic                           q_valid,
  input  logic                           q_ready,
  output logic [SUM_W-1:0]               q_sum,
  output logic [LEN_W-1:0]               q_len,
  output logic                           q_op
);

  logic [SUM_W-1:0] square_sum;
  logic [LEN_W-1:0] chunk_length;
  logic [16:0]      mag;
  logic [16:0]      mag_r;
  logic             mag_v;
  logic             mag_end;
  logic             mag_op;
  logic [33:0]      sq;
  logic             take;
  logic [SUM_W-1:0] sum_add;
  logic [LEN_W-1:0] len_add;

  // one chunk result queued; front stalls only while it is held and a new end arrives
  assign in_ready = !(mag_v && mag_end && q_valid && !q_ready);
  assign mag = sample[15] ? (17'h10000 - {1'b0, sample}) : {1'b0, sample};
  assign sq = mag_r * mag_r;
  assign take = chunk_length < LEN_W'(MAX_CHUNK);
  assign sum_add = square_sum + (take ? SUM_W'(sq) : '0);
  assign len_add = chunk_length + (take ? LEN_W'(1) : '0);

  always_ff @(posedge clk) begin
    if (rst) begin
      mag_v <= 1'b0;
      square_sum <= '0;
      chunk_length <= '0;
      q_valid <= 1'b0;
    end else begin
      if (mag_v && in_ready && mag_end) begin
        q_valid <= 1'b1;
      end else if (q_ready) begin
        q_valid <= 1'b0;
      end
      if (mag_v && in_ready) begin
        if (mag_end) begin
          q_sum <= sum_add;
          q_len <= len_add;
          q_op <= mag_op;
          square_sum <= '0;
          chunk_length <= '0;
        end else begin
          square_sum <= sum_add;
          chunk_length <= len_add;
        end
      end
      if (in_ready) mag_v <= in_valid;
      if (in_valid && in_ready) begin
        mag_r <= mag;
        mag_end <= chunk_end;
        mag_op <= opcode;
      end
    end
  end

endmodule

@@ src/evad_back.sv @@
module evad_back #(
  parameter int HISTORY_DEPTH = evad_pkg::HISTORY_DEPTH_DEF,
  parameter int SUM_W = 45,
  parameter int LEN_W = 13
) (
  input  logic                              clk,
  input  logic                              rst,
  input  logic                              q_valid,
  output logic                              q_ready,
  input  logic [SUM_W-1:0]                  q_sum,
  input  logic [LEN_W-1:0]                  q_len,
  input  logic                              q_op,
  input  logic [evad_pkg::RATIO_W-1:0]      speech_ratio_q4,
  input  logic [evad_pkg::RATIO_W-1:0]      floor_ratio_q4,
  input  logic [evad_pkg::COUNT_W-1:0]      min_history,
  output logic                              out_valid,
  input  logic                              out_ready,
  output logic [evad_pkg::RMS_W-1:0]        volume,
  output logic [evad_pkg::RMS_W-1:0]        noise_floor,
  output logic                              speech_detected,
  output logic [evad_pkg::COUNT_W-1:0]      history_count
);

  localparam int HW = $clog2(HISTORY_DEPTH);
  localparam int FW = $clog2(HISTORY_DEPTH + 1);
  localparam int CW = evad_pkg::COUNT_W;
  localparam int CMP_W = (FW > CW) ? FW : CW;
  localparam int DSTEPS = SUM_W;

  evad_pkg::back_state_t state, state_next;

  logic [SUM_W-1:0] quo;
  logic [LEN_W:0]   rem;
  logic [LEN_W-1:0] divisor;
  logic [$clog2(DSTEPS+1)-1:0] step;
  logic [63:0]      sv;
  logic [31:0]      res;
  logic [5:0]       sstep;
  logic [33:0]      srem;
  logic             op;
  logic [15:0]      mem [HISTORY_DEPTH];
  logic [15:0]      rd;
  logic [HW-1:0]    head;
  logic [FW-1:0]    fill;
  logic [FW-1:0]    scan_i;
  logic             rd_v;
  logic [15:0]      lo;
  logic [23:0]      prod;
  logic [15:0]      volume_level;
  logic [15:0]      floor_level;
  logic [LEN_W:0]   rem_sh;
  logic [33:0]      trial;
  logic [33:0]      srem_sh;

  assign q_ready = (state == evad_pkg::ST_IDLE);
  assign out_valid = (state == evad_pkg::ST_OUT);
  assign rem_sh = {rem[LEN_W-1:0], quo[SUM_W-1]};
  assign srem_sh = {srem[31:0], sv[63:62]};
  assign trial = {res, 2'b01};
  assign prod = lo * floor_ratio_q4;
  assign volume = volume_level;
  assign noise_floor = floor_level;
  assign history_count = CW'(fill);
  assign speech_detected = ({4'b0, volume_level, 4'b0} >
                            (24'(floor_level) * 24'(speech_ratio_q4)));

  always_comb begin
    state_next = state;
    case (state)
      evad_pkg::ST_IDLE:  if (q_valid) state_next = evad_pkg::ST_DIV;
      evad_pkg::ST_DIV:   if (step == DSTEPS[$bits(step)-1:0]) state_next = evad_pkg::ST_SQRT;
      evad_pkg::ST_SQRT:  if (sstep == 6'd32) state_next = op ? evad_pkg::ST_SCAN
                                                           : evad_pkg::ST_OUT;
      evad_pkg::ST_SCAN:  if (CMP_W'(fill) <= CMP_W'(min_history)) state_next = evad_pkg::ST_OUT;
                          else if (rd_v && scan_i == fill) state_next = evad_pkg::ST_SCALE;
      evad_pkg::ST_SCALE: state_next = evad_pkg::ST_OUT;
      evad_pkg::ST_OUT:   if (out_ready) state_next = evad_pkg::ST_IDLE;
      default:            state_next = evad_pkg::ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= evad_pkg::ST_IDLE;
      head <= '0;
      fill <= '0;
      volume_level <= '0;
      floor_level <= evad_pkg::FLOOR_RESET;
    end else begin
      state <= state_next;
      case (state)
        evad_pkg::ST_IDLE: begin
          quo <= q_sum;
          divisor <= q_len;
          rem <= '0;
          step <= '0;
          op <= q_op;
        end
        evad_pkg::ST_DIV: begin
          // restoring long division, one quotient bit a cycle
          if (step != DSTEPS[$bits(step)-1:0]) begin
            step <= step + 1'b1;
            if (rem_sh >= {1'b0, divisor}) begin
              rem <= rem_sh - {1'b0, divisor};
              quo <= {quo[SUM_W-2:0], 1'b1};
            end else begin
              rem <= rem_sh;
              quo <= {quo[SUM_W-2:0], 1'b0};
            end
          end else begin
            sv <= 64'(quo);
            res <= '0;
            srem <= '0;
            sstep <= '0;
          end
        end
        evad_pkg::ST_SQRT: begin
          // digit-by-digit root, two radicand bits a cycle
          if (sstep != 6'd32) begin
            sstep <= sstep + 1'b1;
            sv <= {sv[61:0], 2'b00};
            if (srem_sh >= trial) begin
              srem <= srem_sh - trial;
              res <= {res[30:0], 1'b1};
            end else begin
              srem <= srem_sh;
              res <= {res[30:0], 1'b0};
            end
          end else if (!op) begin
            volume_level <= res[15:0];
          end else begin
            mem[head] <= res[15:0];
            head <= (head == HW'(HISTORY_DEPTH - 1)) ? '0 : head + 1'b1;
            if (fill != FW'(HISTORY_DEPTH)) fill <= fill + 1'b1;
            scan_i <= '0;
            rd_v <= 1'b0;
            lo <= '1;
          end
        end
        evad_pkg::ST_SCAN: begin
          if (scan_i != fill) begin
            rd <= mem[scan_i[HW-1:0]];
            scan_i <= scan_i + 1'b1;
          end
          rd_v <= (scan_i != fill);
          if (rd_v && rd < lo) lo <= rd;
        end
        evad_pkg::ST_SCALE: begin
          floor_level <= (prod[23:20] != 4'd0) ? 16'hFFFF : prod[19:4];
        end
        default: ;
      endcase
    end
  end

endmodule
